/* rtl/rpg_pkg.sv */
// Shared types, constants and the prescaler divisor table of the pattern generator.
package rpg_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int PIN_WIDTH     = 4;
  localparam int IDX_W         = $clog2(PATTERN_DEPTH);
  localparam int ADDR_W        = 7;
  localparam int DATA_W        = 8;
  localparam int SEL_W         = 4;
  localparam int CNT_W         = 22;

  localparam logic [ADDR_W-1:0] REG_CLOCK_SELECT = ADDR_W'(PATTERN_DEPTH);
  localparam logic [ADDR_W-1:0] REG_LAST_INDEX   = ADDR_W'(PATTERN_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_ENTRY       = IDX_W'(PATTERN_DEPTH - 1);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2
  } req_kind_t;

  // Base clock ticks per sequence step for each clock select; select 0 is off.
  function automatic logic [CNT_W-1:0] divisor(input logic [SEL_W-1:0] sel);
    logic [CNT_W-1:0] div;
    case (sel)
      4'd1:    div = CNT_W'(1);
      4'd2:    div = CNT_W'(2);
      4'd3:    div = CNT_W'(4);
      4'd4:    div = CNT_W'(20);
      4'd5:    div = CNT_W'(40);
      4'd6:    div = CNT_W'(200);
      4'd7:    div = CNT_W'(400);
      4'd8:    div = CNT_W'(2000);
      4'd9:    div = CNT_W'(4000);
      4'd10:   div = CNT_W'(20000);
      4'd11:   div = CNT_W'(40000);
      4'd12:   div = CNT_W'(200000);
      4'd13:   div = CNT_W'(400000);
      4'd14:   div = CNT_W'(2000000);
      4'd15:   div = CNT_W'(4000000);
      default: div = '0;
    endcase
    return div;
  endfunction

endpackage

/* rtl/rpg_if.sv */
// Request and response channel interfaces of the pattern generator.
interface rpg_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [rpg_pkg::ADDR_W-1:0]      reg_addr;
  logic [rpg_pkg::DATA_W-1:0]      write_data;

  modport source (output valid, req_type, reg_addr, write_data, input ready);
  modport sink   (input valid, req_type, reg_addr, write_data, output ready);
endinterface

interface rpg_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rpg_pkg::DATA_W-1:0]      read_data;
  logic [rpg_pkg::PIN_WIDTH-1:0]   pin_state;
  logic [5:0]                      step_index;

  modport source (output valid, read_data, pin_state, step_index, input ready);
  modport sink   (input valid, read_data, pin_state, step_index, output ready);
endinterface

/* rtl/ram_pattern_generator.sv */
// Top level of the register-mapped pattern generator.
//
// Usage: every request beat on req (write, read or one base clock tick)
// yields exactly one response beat on rsp carrying read_data (register
// contents for a read, zero otherwise), the pin nibble and the sequence
// index as they stand after the request took effect. Addresses 0..63 hold
// pattern entries, 64 the clock select, 65 the last index.
// An accepted beat passes through the RAM read stage and then the output
// register before it is presented on rsp. Throughput: one beat per cycle
// while rsp takes its beats, with the registers updated and each pattern RAM
// port read once per beat.
// When rsp stalls, one more request beat is taken into the RAM read stage
// before req.ready drops; no beat is lost or repeated.
// Reset (rst, synchronous) clears all pattern entries (per-entry valid
// flags), stops the clock, sets the last index to 63 and zeroes the
// prescaler and sequence index; there is no clearing pass.
module ram_pattern_generator (
  input  logic          clk,
  input  logic          rst,
  rpg_req_if.sink       req,
  rpg_rsp_if.source     rsp
);

  localparam int IDX_W = rpg_pkg::IDX_W;
  localparam int PW    = rpg_pkg::PIN_WIDTH;
  localparam int DW    = rpg_pkg::DATA_W;
  localparam int SW    = rpg_pkg::SEL_W;
  localparam int CW    = rpg_pkg::CNT_W;

  // architectural state
  logic [SW-1:0]                  clock_select, clock_select_next;
  logic [IDX_W-1:0]               last_index, last_index_next;
  logic [CW-1:0]                  prescale_count, prescale_count_next;
  logic [IDX_W-1:0]               sequence_index, sequence_index_next;
  logic [rpg_pkg::PATTERN_DEPTH-1:0] entry_valid;

  // RAM read stage
  logic             s1_valid;
  logic             s1_rd_pat;
  logic [DW-1:0]    s1_rd_val;
  logic             s1_pat_ok;
  logic             s1_fwd;
  logic [PW-1:0]    s1_fwd_data;
  logic             s1_pin_ok;
  logic [IDX_W-1:0] s1_seq;

  // output register
  logic             out_valid;
  logic [DW-1:0]    out_read_data;
  logic [PW-1:0]    out_pin;
  logic [IDX_W-1:0] out_seq;

  logic             accept, out_load, s1_move;
  logic             is_wr, is_rd, is_tick, pat_sel, pat_we;
  logic [IDX_W-1:0] idx;
  logic [CW-1:0]    div;
  logic [DW-1:0]    rd_val;
  logic [PW-1:0]    ram_a, ram_b;
  logic [DW-1:0]    s1_read_data;
  logic [PW-1:0]    s1_pin;

  assign out_load  = !out_valid || rsp.ready;
  assign s1_move   = s1_valid && out_load;
  assign req.ready = !s1_valid || out_load;
  assign accept    = req.valid && req.ready;

  assign is_wr   = accept && (req.req_type == rpg_pkg::REQ_WRITE);
  assign is_rd   = accept && (req.req_type == rpg_pkg::REQ_READ);
  assign is_tick = accept && (req.req_type == rpg_pkg::REQ_TICK);
  assign pat_sel = req.reg_addr < rpg_pkg::ADDR_W'(rpg_pkg::PATTERN_DEPTH);
  assign idx     = req.reg_addr[IDX_W-1:0];
  assign pat_we  = is_wr && pat_sel;
  assign div     = rpg_pkg::divisor(clock_select);

  always_comb begin
    clock_select_next   = clock_select;
    last_index_next     = last_index;
    prescale_count_next = prescale_count;
    sequence_index_next = sequence_index;
    if (is_wr && req.reg_addr == rpg_pkg::REG_CLOCK_SELECT) begin
      clock_select_next = req.write_data[SW-1:0];
    end
    if (is_wr && req.reg_addr == rpg_pkg::REG_LAST_INDEX) begin
      last_index_next = req.write_data[IDX_W-1:0];
    end
    if (is_tick && clock_select != '0) begin
      if ({1'b0, prescale_count} + (CW+1)'(1) >= {1'b0, div}) begin
        prescale_count_next = '0;
        // wrap at the last index, or if the index already lies past it
        if (sequence_index >= last_index || sequence_index == rpg_pkg::LAST_ENTRY) begin
          sequence_index_next = '0;
        end else begin
          sequence_index_next = sequence_index + IDX_W'(1);
        end
      end else begin
        prescale_count_next = prescale_count + CW'(1);
      end
    end
  end

  always_comb begin
    rd_val = '0;
    if (req.reg_addr == rpg_pkg::REG_CLOCK_SELECT) begin
      rd_val = DW'(clock_select);
    end else if (req.reg_addr == rpg_pkg::REG_LAST_INDEX) begin
      rd_val = DW'(last_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_select   <= '0;
      last_index     <= rpg_pkg::LAST_ENTRY;
      prescale_count <= '0;
      sequence_index <= '0;
      entry_valid    <= '0;
    end else begin
      clock_select   <= clock_select_next;
      last_index     <= last_index_next;
      prescale_count <= prescale_count_next;
      sequence_index <= sequence_index_next;
      if (pat_we) begin
        entry_valid[idx] <= 1'b1;
      end
    end
  end

  rpg_ram #(
    .WIDTH (PW),
    .DEPTH (rpg_pkg::PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk     (clk),
    .we      (pat_we),
    .waddr   (idx),
    .wdata   (req.write_data[PW-1:0]),
    .re      (accept),
    .raddr_a (idx),
    .raddr_b (sequence_index_next),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // RAM read returns old data on a same-beat write to the pin entry: forward it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_pat   <= is_rd && pat_sel;
      s1_rd_val   <= (is_rd && !pat_sel) ? rd_val : '0;
      s1_pat_ok   <= entry_valid[idx];
      s1_fwd      <= pat_we && (idx == sequence_index_next);
      s1_fwd_data <= req.write_data[PW-1:0];
      s1_pin_ok   <= entry_valid[sequence_index_next];
      s1_seq      <= sequence_index_next;
    end
  end

  assign s1_read_data = s1_rd_pat ? (s1_pat_ok ? DW'(ram_a) : '0) : s1_rd_val;
  assign s1_pin       = s1_fwd ? s1_fwd_data : (s1_pin_ok ? ram_b : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_read_data <= s1_read_data;
      out_pin       <= s1_pin;
      out_seq       <= s1_seq;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_read_data;
  assign rsp.pin_state  = out_pin;
  assign rsp.step_index = out_seq;

endmodule

/* rtl/rpg_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module rpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
